### src/gas_pkg.sv
// gas_pkg: shared types, codes and constants of the gimbal aim sequencer
// used by gas_csr, gas_step and gimbal_aim_sequencer_top; no dependencies
package gas_pkg;

   // coordinate width default and error width
   localparam int COORD_BITS_DEF = 10;
   localparam int ERR_W          = 16;   // widest coordinate error

   // phase codes
   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_LEFT   = 3'd1;
   localparam logic [2:0] PH_RIGHT  = 3'd2;
   localparam logic [2:0] PH_SEARCH = 3'd3;
   localparam logic [2:0] PH_AIM    = 3'd4;
   localparam logic [2:0] PH_FIRE   = 3'd5;

   // input codes
   localparam logic       FUNC_TICK    = 1'b0;
   localparam logic       FUNC_RESTART = 1'b1;
   localparam logic [1:0] MODE_WAIT    = 2'd0;
   localparam logic [1:0] MODE_AIM     = 2'd1;
   localparam logic [1:0] MODE_LEFT    = 2'd2;
   localparam logic [1:0] MODE_RIGHT   = 2'd3;

   // notify codes
   localparam logic [1:0] NOTE_NONE   = 2'd0;
   localparam logic [1:0] NOTE_SPEED  = 2'd1;
   localparam logic [1:0] NOTE_ANGLE  = 2'd2;
   localparam logic [1:0] NOTE_CANCEL = 2'd3;

   // register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_SPEED    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DETECT_FRAMES = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STABLE_FRAMES = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_YAW_TOL       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_START   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_STOP    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COARSE        = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_MEDIUM        = 3'd7;
   localparam int CSR_DATA_W = 10;

   // step magnitudes in hundredths of a degree
   localparam logic [9:0] STEP_COARSE = 10'd500;
   localparam logic [9:0] STEP_MEDIUM = 10'd100;
   localparam logic [9:0] STEP_SMALL  = 10'd10;
   localparam logic [9:0] STEP_FINE   = 10'd1;
   localparam logic [ERR_W-1:0] SMALL_LIMIT = 16'd5;

   // result packing
   localparam int RSP_FIELDS_W = 33;
   localparam int RSP_DATA_W   = 40;

   typedef struct packed {
      logic [5:0] scan_speed;
      logic [3:0] detect_frames;
      logic [3:0] stable_frames;
      logic [9:0] yaw_tolerance;
      logic [9:0] pitch_start_error;
      logic [9:0] pitch_stop_error;
      logic [9:0] coarse_threshold;
      logic [9:0] medium_threshold;
   } gas_cfg_type;

   typedef struct packed {
      logic [2:0]        phase;
      logic [3:0]        detect_count;
      logic [3:0]        yaw_stable_count;
      logic [3:0]        pitch_stable_count;
      logic              yaw_locked;
      logic              pitch_locked;
      logic              pitch_fine_enable;
      logic signed [6:0] yaw_speed;
      logic signed [9:0] yaw_step;
      logic signed [9:0] pitch_step;
   } gas_state_type;

   typedef struct packed {
      logic signed [6:0] yaw_speed;
      logic signed [9:0] yaw_step;
      logic signed [9:0] pitch_step;
      logic [1:0]        notify;
      logic              done_res;
      logic [2:0]        phase;
   } gas_result_type;

   // step magnitude from absolute error and thresholds
   function automatic logic [9:0] step_mag(input logic [ERR_W-1:0] err,
                                           input logic [9:0] coarse_thr,
                                           input logic [9:0] mid_thr,
                                           input logic fine);
      logic [9:0] mag;
      if (err > {{(ERR_W-10){1'b0}}, coarse_thr})
         mag = STEP_COARSE;
      else if (err > {{(ERR_W-10){1'b0}}, mid_thr})
         mag = STEP_MEDIUM;
      else if (err > SMALL_LIMIT)
         mag = STEP_SMALL;
      else if ((err != '0) && fine)
         mag = STEP_FINE;
      else
         mag = '0;
      return mag;
   endfunction

endpackage

### src/gas_csr.sv
// gas_csr: configuration register file of the aim sequencer
// depends on gas_pkg for register indexes and the config struct
module gas_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [gas_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gas_pkg::CSR_DATA_W-1:0]      csr_data,
   output gas_pkg::gas_cfg_type                cfg
);

   gas_pkg::gas_cfg_type cfg_ff;
   gas_pkg::gas_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            gas_pkg::CSR_SCAN_SPEED:    cfg_in.scan_speed        = csr_data[5:0];
            gas_pkg::CSR_DETECT_FRAMES: cfg_in.detect_frames     = csr_data[3:0];
            gas_pkg::CSR_STABLE_FRAMES: cfg_in.stable_frames     = csr_data[3:0];
            gas_pkg::CSR_YAW_TOL:       cfg_in.yaw_tolerance     = csr_data;
            gas_pkg::CSR_PITCH_START:   cfg_in.pitch_start_error = csr_data;
            gas_pkg::CSR_PITCH_STOP:    cfg_in.pitch_stop_error  = csr_data;
            gas_pkg::CSR_COARSE:        cfg_in.coarse_threshold  = csr_data;
            gas_pkg::CSR_MEDIUM:        cfg_in.medium_threshold  = csr_data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scan_speed        <= 6'd12;
         cfg_ff.detect_frames     <= 4'd5;
         cfg_ff.stable_frames     <= 4'd5;
         cfg_ff.yaw_tolerance     <= 10'd4;
         cfg_ff.pitch_start_error <= 10'd5;
         cfg_ff.pitch_stop_error  <= 10'd3;
         cfg_ff.coarse_threshold  <= 10'd150;
         cfg_ff.medium_threshold  <= 10'd50;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### src/gas_step.sv
// gas_step: next-state and result logic for one control tick
// depends on gas_pkg for codes, step function and state/result structs
module gas_step #(
   parameter int COORD_BITS = gas_pkg::COORD_BITS_DEF
) (
   input  gas_pkg::gas_cfg_type      cfg,
   input  gas_pkg::gas_state_type    state_cur,
   input  logic                      func,
   input  logic [1:0]                mode,
   input  logic                      frame_ready,
   input  logic [COORD_BITS-1:0]     tgt_x,
   input  logic [COORD_BITS-1:0]     tgt_y,
   input  logic [COORD_BITS-1:0]     laser_x,
   input  logic [COORD_BITS-1:0]     laser_y,
   output gas_pkg::gas_state_type    state_nxt,
   output gas_pkg::gas_result_type   result
);

   localparam int EW = gas_pkg::ERR_W;

   logic [COORD_BITS-1:0] ex_raw, ey_raw;
   logic [EW-1:0]         ex, ey;
   logic [EW-1:0]         yaw_tol, pitch_start, pitch_stop;
   logic                  fine_nxt;
   logic [9:0]            yaw_mag, pitch_mag;
   logic signed [9:0]     yaw_step_new, pitch_step_new;
   logic [3:0]            ycnt_inc, pcnt_inc, dcnt_inc;
   logic                  ylock_hit, plock_hit;
   logic [1:0]            notify;
   logic                  done;

   assign ex_raw = (tgt_x >= laser_x) ? tgt_x - laser_x : laser_x - tgt_x;
   assign ey_raw = (tgt_y >= laser_y) ? tgt_y - laser_y : laser_y - tgt_y;
   assign ex = EW'(ex_raw);
   assign ey = EW'(ey_raw);

   assign yaw_tol     = EW'(cfg.yaw_tolerance);
   assign pitch_start = EW'(cfg.pitch_start_error);
   assign pitch_stop  = EW'(cfg.pitch_stop_error);

   // pitch fine stepping hysteresis
   always_comb begin
      if (ey > pitch_start)
         fine_nxt = 1'b1;
      else if (ey <= pitch_stop)
         fine_nxt = 1'b0;
      else
         fine_nxt = state_cur.pitch_fine_enable;
   end

   assign yaw_mag   = gas_pkg::step_mag(ex, cfg.coarse_threshold, cfg.medium_threshold, 1'b1);
   assign pitch_mag = gas_pkg::step_mag(ey, cfg.coarse_threshold, cfg.medium_threshold,
                                        fine_nxt);
   assign yaw_step_new   = (tgt_x > laser_x) ? $signed(yaw_mag) : -$signed(yaw_mag);
   assign pitch_step_new = (tgt_y > laser_y) ? $signed(pitch_mag) : -$signed(pitch_mag);

   // stable counters, zero on an out-of-tolerance frame
   assign ycnt_inc  = (ex <= yaw_tol)    ? state_cur.yaw_stable_count + 4'd1   : 4'd0;
   assign pcnt_inc  = (ey <= pitch_stop) ? state_cur.pitch_stable_count + 4'd1 : 4'd0;
   assign ylock_hit = ycnt_inc >= cfg.stable_frames;
   assign plock_hit = pcnt_inc >= cfg.stable_frames;
   assign dcnt_inc  = state_cur.detect_count + 4'd1;

   always_comb begin
      state_nxt = state_cur;
      notify    = gas_pkg::NOTE_NONE;
      done      = 1'b0;
      if (func == gas_pkg::FUNC_RESTART) begin
         state_nxt = '0;
         state_nxt.phase = gas_pkg::PH_IDLE;
         notify = gas_pkg::NOTE_SPEED;
      end else begin
         case (state_cur.phase)
            gas_pkg::PH_LEFT: begin
               state_nxt.yaw_speed = -$signed({1'b0, cfg.scan_speed});
               notify = gas_pkg::NOTE_SPEED;
               state_nxt.phase = gas_pkg::PH_SEARCH;
            end
            gas_pkg::PH_RIGHT: begin
               state_nxt.yaw_speed = $signed({1'b0, cfg.scan_speed});
               notify = gas_pkg::NOTE_SPEED;
               state_nxt.phase = gas_pkg::PH_SEARCH;
            end
            gas_pkg::PH_SEARCH: begin
               if (frame_ready) begin
                  state_nxt.detect_count = dcnt_inc;
                  if (dcnt_inc >= cfg.detect_frames) begin
                     state_nxt.detect_count = 4'd0;
                     state_nxt.yaw_speed = '0;
                     notify = gas_pkg::NOTE_CANCEL;
                     state_nxt.phase = gas_pkg::PH_AIM;
                  end
               end
            end
            gas_pkg::PH_AIM: begin
               if (frame_ready) begin
                  state_nxt.pitch_fine_enable = fine_nxt;
                  state_nxt.yaw_stable_count   = ylock_hit ? 4'd0 : ycnt_inc;
                  state_nxt.pitch_stable_count = plock_hit ? 4'd0 : pcnt_inc;
                  state_nxt.yaw_locked   = state_cur.yaw_locked | ylock_hit;
                  state_nxt.pitch_locked = state_cur.pitch_locked | plock_hit;
                  state_nxt.yaw_step   = state_nxt.yaw_locked   ? '0 : yaw_step_new;
                  state_nxt.pitch_step = state_nxt.pitch_locked ? '0 : pitch_step_new;
                  if (state_nxt.yaw_locked && state_nxt.pitch_locked)
                     state_nxt.phase = gas_pkg::PH_FIRE;
                  notify = gas_pkg::NOTE_ANGLE;
               end
            end
            gas_pkg::PH_FIRE: begin
               state_nxt.yaw_locked = 1'b0;
               state_nxt.pitch_locked = 1'b0;
               state_nxt.pitch_fine_enable = 1'b0;
               state_nxt.phase = gas_pkg::PH_IDLE;
               done = 1'b1;
            end
            default: begin
               // idle, and unused codes act as idle
               state_nxt.pitch_fine_enable = 1'b0;
               case (mode)
                  gas_pkg::MODE_AIM:   state_nxt.phase = gas_pkg::PH_AIM;
                  gas_pkg::MODE_LEFT:  state_nxt.phase = gas_pkg::PH_LEFT;
                  gas_pkg::MODE_RIGHT: state_nxt.phase = gas_pkg::PH_RIGHT;
                  default:             state_nxt.phase = gas_pkg::PH_IDLE;
               endcase
            end
         endcase
      end
   end

   assign result.yaw_speed  = state_nxt.yaw_speed;
   assign result.yaw_step   = state_nxt.yaw_step;
   assign result.pitch_step = state_nxt.pitch_step;
   assign result.notify     = notify;
   assign result.done_res   = done;
   assign result.phase      = state_nxt.phase;

endmodule

### src/gimbal_aim_sequencer_top.sv
// gimbal_aim_sequencer_top: stream wrapper with input register, step logic and
// result register; depends on gas_pkg, gas_csr and gas_step
//
// path: a req item passes through the input register and then the result register
//   before rsp_tvalid rises for it
// throughput: one item per cycle while rsp_tready is high; single pass of compares and adds
// reset: synchronous active high; clears phase, counters, locks, held outputs,
//   both valid flags and reloads the configuration defaults; no clearing pass
module gimbal_aim_sequencer_top #(
   parameter int COORD_BITS = gas_pkg::COORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata fields from bit 0: mode, frame_ready, target_x, target_y, laser_x, laser_y
   input  logic [((3+4*COORD_BITS+7)/8)*8-1:0] req_tdata,
   // tuser: func
   input  logic                              req_tuser,
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata fields from bit 0: yaw_speed, yaw_step, pitch_step, notify, done_res, phase
   output logic [gas_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // configuration write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gas_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gas_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int CB = COORD_BITS;

   // config registers
   gas_pkg::gas_cfg_type cfg;

   gas_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // writes are always taken
   assign csr_ready = 1'b1;

   // input register
   logic          in_valid_ff;
   logic          in_func_ff;
   logic [1:0]    in_mode_ff;
   logic          in_frame_ff;
   logic [CB-1:0] in_tx_ff, in_ty_ff, in_lx_ff, in_ly_ff;

   // tracking state and result register
   gas_pkg::gas_state_type  state_ff, state_in;
   gas_pkg::gas_result_type result_in, rsp_data_ff;
   logic                    rsp_valid_ff;

   logic advance;   // result register can take the item in the input register

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_func_ff  <= req_tuser;
         in_mode_ff  <= req_tdata[1:0];
         in_frame_ff <= req_tdata[2];
         in_tx_ff    <= req_tdata[3 +: CB];
         in_ty_ff    <= req_tdata[3 + CB +: CB];
         in_lx_ff    <= req_tdata[3 + 2*CB +: CB];
         in_ly_ff    <= req_tdata[3 + 3*CB +: CB];
      end
   end

   gas_step #(.COORD_BITS(COORD_BITS)) u_step (
      .cfg         (cfg),
      .state_cur   (state_ff),
      .func        (in_func_ff),
      .mode        (in_mode_ff),
      .frame_ready (in_frame_ff),
      .tgt_x       (in_tx_ff),
      .tgt_y       (in_ty_ff),
      .laser_x     (in_lx_ff),
      .laser_y     (in_ly_ff),
      .state_nxt   (state_in),
      .result      (result_in)
   );

   // state moves only when an item passes into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= '0;
         state_ff.phase <= gas_pkg::PH_IDLE;
         rsp_valid_ff   <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
         if (in_valid_ff)
            state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff)
         rsp_data_ff <= result_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(gas_pkg::RSP_DATA_W - gas_pkg::RSP_FIELDS_W){1'b0}},
                        rsp_data_ff.phase,
                        rsp_data_ff.done_res,
                        rsp_data_ff.notify,
                        rsp_data_ff.pitch_step,
                        rsp_data_ff.yaw_step,
                        rsp_data_ff.yaw_speed};

   // done pulse always lands in idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.done_res |-> rsp_data_ff.phase == gas_pkg::PH_IDLE)
      else $error("done_res outside idle");

   // cancel only on the search-to-aim transition
   a_cancel_aim: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.notify == gas_pkg::NOTE_CANCEL
      |-> rsp_data_ff.phase == gas_pkg::PH_AIM)
      else $error("cancel notify outside aim entry");

   // both axes locked means fire phase
   a_lock_fire: assert property (@(posedge clock) disable iff (reset)
      state_ff.yaw_locked && state_ff.pitch_locked |-> state_ff.phase == gas_pkg::PH_FIRE)
      else $error("both axes locked outside fire phase");

   // state frozen while no item passes
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !(advance && in_valid_ff) |=> $stable(state_ff))
      else $error("state changed without an item");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !in_valid_ff)
      else $error("valid set after reset");

endmodule
